[hdl/mtk_pkg.sv]
// ---------------------------------------------------------------------------
// mtk_pkg: shared types and tables for the morse tone keyer
// code table, microcode word layout and the sequencer program
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtk_pkg;

  localparam int unsigned UnitW   = 9;
  localparam int unsigned OnW     = 11;
  localparam int unsigned OffW    = 12;
  localparam int unsigned SymW    = 5;   // most symbols in one character
  localparam int unsigned LenW    = 3;
  localparam int unsigned StepW   = 2;
  localparam int unsigned NumSteps = 4;
  localparam int unsigned NumCodes = 36;

  localparam logic [UnitW-1:0] UnitReset = 9'd100;

  // program addresses
  localparam logic [StepW-1:0] StepWait     = 2'd0;
  localparam logic [StepW-1:0] StepDispatch = 2'd1;
  localparam logic [StepW-1:0] StepGap      = 2'd2;
  localparam logic [StepW-1:0] StepSym      = 2'd3;

  // jump conditions, jump taken when true, otherwise step + 1
  typedef enum logic [1:0] {
    CondAlways  = 2'd0,
    CondNoStart = 2'd1,
    CondKnown   = 2'd2,
    CondMore    = 2'd3
  } cond_e;

  typedef struct packed {
    cond_e            cond;
    logic [StepW-1:0] target;
    logic             busy;
    logic             emit_sym;
    logic             emit_gap;
  } ctrl_t;

  // pattern is first symbol in bit 0, 1 means dash
  typedef struct packed {
    logic            known;
    logic [LenW-1:0] len;
    logic [SymW-1:0] pat;
  } code_t;

  typedef logic [LenW+SymW-1:0] code_ent_t;

  localparam code_ent_t CodeRom [NumCodes] = '{
    {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001}, // a b c d
    {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000}, // e f g h
    {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010}, // i j k l
    {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110}, // m n o p
    {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001}, // q r s t
    {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001}, // u v w x
    {3'd4, 5'b01101}, {3'd4, 5'b00011},                                     // y z
    {3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000}, // 0 1 2 3
    {3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011}, // 4 5 6 7
    {3'd5, 5'b00111}, {3'd5, 5'b01111}                                      // 8 9
  };

  // wait, dispatch, word gap, symbol loop
  localparam ctrl_t Program [NumSteps] = '{
    '{cond: CondNoStart, target: StepWait, busy: 1'b0, emit_sym: 1'b0, emit_gap: 1'b0},
    '{cond: CondKnown,   target: StepSym,  busy: 1'b1, emit_sym: 1'b0, emit_gap: 1'b0},
    '{cond: CondAlways,  target: StepWait, busy: 1'b1, emit_sym: 1'b0, emit_gap: 1'b1},
    '{cond: CondMore,    target: StepSym,  busy: 1'b1, emit_sym: 1'b1, emit_gap: 1'b0}
  };

  function automatic code_t code_lookup(input logic [7:0] ch);
    code_t       c;
    logic [7:0]  idx;
    code_ent_t   ent;
    c   = '0;
    idx = '0;
    if (ch inside {[8'h41:8'h5A]}) begin
      idx     = ch - 8'h41;
      c.known = 1'b1;
    end else if (ch inside {[8'h30:8'h39]}) begin
      idx     = ch - 8'h30 + 8'd26;
      c.known = 1'b1;
    end
    ent = CodeRom[idx[5:0]];
    if (c.known) begin
      c.len = ent[LenW+SymW-1:SymW];
      c.pat = ent[SymW-1:0];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/morse_tone_keyer.sv]
// ---------------------------------------------------------------------------
// morse_tone_keyer: ascii character to morse tone burst words
// microcoded sequencer that emits a word-gap word or one keying word per symbol
// ---------------------------------------------------------------------------
// usage
//   input: drive character_i and raise start; the character is taken at a
//   clock edge with start high and busy low. busy stays high until the last
//   result word of that character has been produced
//   results: each word sits on tone_on_o, tone_select_o, on_ms_o, off_ms_o
//   and last_o for exactly one cycle, flagged by result_valid_o. the
//   receiver cannot stall, so words must be captured when they appear
//   config: unit_ms_we_i writes unit_ms_i into the unit length register;
//   write it only while busy is low and no word is pending
// timing
//   a letter or digit with n symbols (1 to 5) gives n words on consecutive
//   cycles; the first one is registered from the first symbol step, which
//   comes after the dispatch step. any other character gives one silent
//   word-gap word, registered from the gap step after dispatch. an item
//   runs through the wait, dispatch and one program step per emitted symbol
// reset
//   rst_ni clears the program counter and the result strobe and loads the
//   unit length with 100 ms
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module morse_tone_keyer
  import mtk_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // item channel
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [7:0]       character_i,
  // unit length register
  input  wire logic             unit_ms_we_i,
  input  wire logic [UnitW-1:0] unit_ms_i,
  // result channel
  output logic                  result_valid_o,
  output logic                  tone_on_o,
  output logic                  tone_select_o,
  output logic [OnW-1:0]        on_ms_o,
  output logic [OffW-1:0]       off_ms_o,
  output logic                  last_o
);

  // sequencer state
  logic [StepW-1:0] step_q, step_d;
  ctrl_t            ctrl;
  logic             cond_true;

  // datapath registers
  logic [UnitW-1:0] unit_q;
  logic             known_q;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [SymW-1:0]  pat_q, pat_d;
  code_t            lookup;
  logic             accept;

  // result registers
  logic             valid_q;
  logic             tone_on_q, tone_sel_q, last_q;
  logic [OnW-1:0]   on_ms_q;
  logic [OffW-1:0]  off_ms_q;

  // durations: shifts and one add, no multiplier
  logic [OnW-1:0]   unit_x1, unit_x3;
  logic [OffW-1:0]  unit_x4, unit_x6, unit_off1;
  logic             final_sym;

  // fetch the control word for the current step
  assign ctrl   = Program[step_q];
  assign busy   = ctrl.busy;
  assign accept = start && !busy;
  assign lookup = code_lookup(character_i);

  assign unit_x1   = OnW'(unit_q);
  assign unit_x3   = OnW'({unit_q, 1'b0}) + OnW'(unit_q);
  assign unit_x4   = OffW'({unit_q, 2'b00});
  assign unit_x6   = {unit_x3[OffW-2:0], 1'b0};
  assign unit_off1 = OffW'(unit_q);

  // one symbol left means this is the final burst of the letter
  assign final_sym = (rem_q == LenW'(1));

  always_comb begin
    case (ctrl.cond)
      CondAlways:  cond_true = 1'b1;
      CondNoStart: cond_true = !start;
      CondKnown:   cond_true = known_q;
      CondMore:    cond_true = !final_sym;
      default:     cond_true = 1'b1;
    endcase
  end

  // conditional jump, otherwise fall through; symbol step wraps to wait
  assign step_d = cond_true ? ctrl.target : step_q + StepW'(1);

  always_comb begin
    rem_d = rem_q;
    pat_d = pat_q;
    if (accept) begin
      rem_d = lookup.len;
      pat_d = lookup.pat;
    end else if (ctrl.emit_sym) begin
      rem_d = rem_q - LenW'(1);
      pat_d = pat_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepWait;
      unit_q  <= UnitReset;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= ctrl.emit_sym || ctrl.emit_gap;
      if (unit_ms_we_i) begin
        unit_q <= unit_ms_i;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    pat_q <= pat_d;
    if (accept) begin
      known_q <= lookup.known;
    end
    if (ctrl.emit_sym) begin
      tone_on_q  <= 1'b1;
      tone_sel_q <= pat_q[0];
      on_ms_q    <= pat_q[0] ? unit_x3 : unit_x1;
      off_ms_q   <= final_sym ? unit_x4 : unit_off1;
      last_q     <= final_sym;
    end else begin
      // word gap: silence only
      tone_on_q  <= 1'b0;
      tone_sel_q <= 1'b0;
      on_ms_q    <= '0;
      off_ms_q   <= unit_x6;
      last_q     <= 1'b1;
    end
  end

  assign result_valid_o = valid_q;
  assign tone_on_o      = tone_on_q;
  assign tone_select_o  = tone_sel_q;
  assign on_ms_o        = on_ms_q;
  assign off_ms_o       = off_ms_q;
  assign last_o         = last_q;

  // an accepted character keeps the sequencer busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("sequencer not busy after accept");

  // the final word of a character leaves the sequencer waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (step_q == StepWait))
    else $error("sequencer still running after final word");

  // symbols of one character come out back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !last_q) |=> valid_q)
    else $error("gap inside a character");

  // a silent word is always the word gap, which is final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !tone_on_q) |-> last_q)
    else $error("silent word not marked final");

endmodule

`default_nettype wire
